// File: hw/rtl/packet_rule_first_match_macros.svh
// assertion helpers for the rule classifier
`ifndef PACKET_RULE_FIRST_MATCH_MACROS_SVH
`define PACKET_RULE_FIRST_MATCH_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define PRFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prfm same-cycle check failed");

// next-cycle implication, quiet while reset is asserted
`define PRFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prfm next-cycle check failed");

`endif

// File: hw/rtl/prfm_pkg.sv
package prfm_pkg;

	localparam int RULE_SLOTS_DEFAULT = 64;

	localparam logic [7:0]  PROTO_ANY = 8'd143;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [1:0]  ACK_ANY   = 2'd3;
	localparam logic [15:0] PORT_ANY  = 16'd0;
	localparam logic [15:0] PORT_HIGH = 16'd1023;

	// item action codes
	localparam logic ACT_CLASSIFY = 1'b0;
	localparam logic ACT_WRITE    = 1'b1;

	// configuration register indexes
	localparam logic REG_RULE_COUNT      = 1'b0;
	localparam logic REG_DEFAULT_VERDICT = 1'b1;

	typedef struct packed {
		logic        action;
		logic [5:0]  rule_index;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] src_mask;
		logic [31:0] dst_addr;
		logic [31:0] dst_mask;
		logic [1:0]  direction;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  ack_bits;
		logic [7:0]  rule_verdict;
	} item_t;

	typedef struct packed {
		logic       matched;
		logic [5:0] match_index;
		logic [7:0] verdict;
	} result_t;

	// one table entry
	typedef struct packed {
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] src_mask;
		logic [31:0] dst_addr;
		logic [31:0] dst_mask;
		logic [1:0]  direction;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [1:0]  ack_mask;
		logic [7:0]  verdict;
	} rule_t;

endpackage

// File: hw/rtl/prfm_rule_match.sv
module prfm_rule_match (
	input  prfm_pkg::rule_t rule,
	input  prfm_pkg::item_t pkt,
	output logic            hit
);

	logic proto_ok;
	logic src_ok;
	logic dst_ok;
	logic dir_ok;
	logic sport_ok;
	logic dport_ok;
	logic ack_ok;

	function automatic logic port_hit(input logic [15:0] rport, input logic [15:0] pport);
		logic res;
		res = (rport == prfm_pkg::PORT_ANY) || (rport == pport)
			|| ((rport == prfm_pkg::PORT_HIGH) && (pport >= prfm_pkg::PORT_HIGH));
		return res;
	endfunction

	assign proto_ok = (pkt.protocol == rule.protocol) || (rule.protocol == prfm_pkg::PROTO_ANY);
	assign src_ok   = (pkt.src_addr & rule.src_mask) == (rule.src_addr & rule.src_mask);
	assign dst_ok   = (pkt.dst_addr & rule.dst_mask) == (rule.dst_addr & rule.dst_mask);
	assign dir_ok   = (pkt.direction & rule.direction) != 2'b00;
	assign sport_ok = port_hit(rule.sport, pkt.sport);
	assign dport_ok = port_hit(rule.dport, pkt.dport);
	// ack bits within the mask; a specific ack mask only applies to tcp
	assign ack_ok   = ((pkt.ack_bits & rule.ack_mask) == pkt.ack_bits)
		&& ((rule.ack_mask == prfm_pkg::ACK_ANY) || (pkt.protocol == prfm_pkg::PROTO_TCP));

	assign hit = proto_ok && src_ok && dst_ok && dir_ok && sport_ok && dport_ok && ack_ok;

endmodule

// File: hw/rtl/packet_rule_first_match.sv
// first-match packet classifier over a table of firewall rules
// item channel (item_valid/item_ready/item): a word is either a rule write
//   (action write) storing the rule into slot rule_index, or a classify word
//   carrying packet fields; writes to slots at or above RULE_SLOTS are dropped
// result channel (result_valid/result_ready/result): one word per classify,
//   giving matched, the slot of the first matching rule and its verdict, or
//   the default verdict with index 0 when nothing matches
// config port: cfg_wr_en/cfg_index/cfg_data, index 0 rule_count, 1 default_verdict
// rate: a rule write gives no result; a classify reads one table entry per cycle
//   from the single rule memory, from slot 0 up to the first hit or up to the
//   clipped rule_count on a miss, and its result passes through the holding
//   register res_q into the output register; no further word is accepted until
//   the controller is back in idle, and a clipped rule_count of zero skips the
//   scan and gives the default verdict
// reset: rule_count and default_verdict clear, the controller returns to idle;
//   the table itself holds nothing defined until slots are written
// stall: a result left waiting in the output register does not block the next
//   word; a second finished result waits in its own holding register
module packet_rule_first_match #(
	parameter int RULE_SLOTS = prfm_pkg::RULE_SLOTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  prfm_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output prfm_pkg::result_t result
);

	`include "packet_rule_first_match_macros.svh"

	// table address width and scan counter width
	localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
	localparam int CW = ($clog2(RULE_SLOTS + 1) > 7) ? $clog2(RULE_SLOTS + 1) : 7;

	// controller states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0]        state_q;
	logic [6:0]        rule_count_q;
	logic [7:0]        default_verdict_q;

	prfm_pkg::item_t   pkt_q;       // packet under classification
	logic [CW-1:0]     n_q;         // slots to scan, clipped to the table size
	logic [CW-1:0]     issue_q;     // next slot to read
	prfm_pkg::result_t res_q;       // finished result waiting for the output
	prfm_pkg::result_t result_q;
	logic              result_valid_q;

	// read stage
	prfm_pkg::rule_t   rule_s1;
	logic [AW-1:0]     idx_s1;
	logic              valid_s1;

	prfm_pkg::rule_t   rule_mem [RULE_SLOTS];

	logic              accept;
	logic              start_scan;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	prfm_pkg::rule_t   wr_rule;
	logic              rd_en;
	logic [CW-1:0]     n_clip;
	logic              hit;
	logic              last_s1;
	logic              out_free;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign start_scan   = accept && (item.action == prfm_pkg::ACT_CLASSIFY);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || result_ready;

	// rule_count above the table size only scans the table
	assign n_clip = (CW'(rule_count_q) > CW'(RULE_SLOTS)) ? CW'(RULE_SLOTS) : CW'(rule_count_q);

	// ---- rule table: one write port, one registered read port ----
	assign wr_en   = accept && (item.action == prfm_pkg::ACT_WRITE)
		&& (32'(item.rule_index) < 32'(RULE_SLOTS));
	assign wr_addr = AW'(item.rule_index);
	assign wr_rule = '{
		protocol:  item.protocol,
		src_addr:  item.src_addr,
		src_mask:  item.src_mask,
		dst_addr:  item.dst_addr,
		dst_mask:  item.dst_mask,
		direction: item.direction,
		sport:     item.sport,
		dport:     item.dport,
		ack_mask:  item.ack_bits,
		verdict:   item.rule_verdict
	};

	// reads run only while scanning, writes only in idle, so they never meet
	assign rd_en = (state_q == ST_SCAN) && (issue_q < n_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rule_mem[wr_addr] <= wr_rule;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rule_s1 <= rule_mem[issue_q[AW-1:0]];
			idx_s1  <= issue_q[AW-1:0];
		end
	end

	// ---- compare the entry just read against the packet ----
	prfm_rule_match u_match (
		.rule (rule_s1),
		.pkt  (pkt_q),
		.hit  (hit)
	);

	assign last_s1 = (CW'(idx_s1) == (n_q - CW'(1)));

	// ---- configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_count_q      <= '0;
			default_verdict_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				prfm_pkg::REG_RULE_COUNT:      rule_count_q      <= cfg_data[6:0];
				prfm_pkg::REG_DEFAULT_VERDICT: default_verdict_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---- packet capture ----
	always_ff @(posedge clk) begin
		if (start_scan) begin
			pkt_q <= item;
		end
	end

	// ---- scan controller ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			issue_q  <= '0;
			valid_s1 <= 1'b0;
			res_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					valid_s1 <= 1'b0;
					issue_q  <= '0;
					if (start_scan) begin
						n_q <= n_clip;
						if (n_clip == '0) begin
							// empty table: straight to the default verdict
							res_q   <= '{matched: 1'b0, match_index: 6'd0,
								verdict: default_verdict_q};
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// reads issued past a hit are simply dropped
					if (valid_s1 && hit) begin
						res_q    <= '{matched: 1'b1, match_index: 6'(idx_s1),
							verdict: rule_s1.verdict};
						state_q  <= ST_RESULT;
						valid_s1 <= 1'b0;
					end else if (valid_s1 && last_s1) begin
						res_q    <= '{matched: 1'b0, match_index: 6'd0,
							verdict: default_verdict_q};
						state_q  <= ST_RESULT;
						valid_s1 <= 1'b0;
					end else begin
						valid_s1 <= rd_en;
						if (rd_en) begin
							issue_q <= issue_q + CW'(1);
						end
					end
				end
				ST_RESULT: begin
					valid_s1 <= 1'b0;
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q  <= ST_IDLE;
					valid_s1 <= 1'b0;
				end
			endcase
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			result_q <= res_q;
		end
	end

	// ---- checks ----
	`PRFM_ASSERT_NOW(a_read_within_count, clk, arst_n, valid_s1, (CW'(idx_s1) < n_q))
	`PRFM_ASSERT_NOW(a_scan_nonempty, clk, arst_n, (state_q == ST_SCAN), (n_q != '0))
	`PRFM_ASSERT_NOW(a_issue_bounded, clk, arst_n, (state_q == ST_SCAN), (issue_q <= n_q))
	`PRFM_ASSERT_NEXT(a_classify_starts, clk, arst_n, start_scan, (state_q != ST_IDLE))

endmodule

// File: sim/packet_rule_first_match_test.sv
module packet_rule_first_match_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = prfm_pkg::RULE_SLOTS_DEFAULT;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	// long enough to cover a full-table scan plus the output registers
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 400;
	localparam int WORDS_PER_PHASE = 240;
	localparam int PHASES = 7;

	// scoreboard: mirrors the rule table and registers, predicts one verdict per classify
	class verdict_board;
		prfm_pkg::rule_t   rules [SLOTS];
		logic [6:0]        rule_count;
		logic [7:0]        default_verdict;
		prfm_pkg::result_t expected_verdicts [$];
		int                errors;
		int                classified;
		int                hits;
		int                rule_writes;

		function new();
			rule_count = '0;
			default_verdict = '0;
			errors = 0;
			classified = 0;
			hits = 0;
			rule_writes = 0;
		endfunction

		function void set_reg(logic idx, logic [7:0] value);
			if (idx == prfm_pkg::REG_RULE_COUNT) begin
				rule_count = value[6:0];
			end else begin
				default_verdict = value;
			end
		endfunction

		function bit port_ok(logic [15:0] rport, logic [15:0] pkt_port);
			return rport == prfm_pkg::PORT_ANY || rport == pkt_port
				|| (rport == prfm_pkg::PORT_HIGH && pkt_port >= prfm_pkg::PORT_HIGH);
		endfunction

		function bit rule_hits(prfm_pkg::rule_t r, prfm_pkg::item_t p);
			if (r.protocol != p.protocol && r.protocol != prfm_pkg::PROTO_ANY) return 1'b0;
			if ((p.src_addr & r.src_mask) != (r.src_addr & r.src_mask)) return 1'b0;
			if ((p.dst_addr & r.dst_mask) != (r.dst_addr & r.dst_mask)) return 1'b0;
			if ((r.direction & p.direction) == 2'd0) return 1'b0;
			if (!port_ok(r.sport, p.sport)) return 1'b0;
			if (!port_ok(r.dport, p.dport)) return 1'b0;
			// a specific ack mask only applies to tcp
			if (r.ack_mask != prfm_pkg::ACK_ANY && p.protocol != prfm_pkg::PROTO_TCP)
				return 1'b0;
			if ((p.ack_bits & r.ack_mask) != p.ack_bits) return 1'b0;
			return 1'b1;
		endfunction

		// called for every word the block accepts, in order
		function void note_word(prfm_pkg::item_t w);
			prfm_pkg::result_t want;
			int                scan;
			if (w.action == prfm_pkg::ACT_WRITE) begin
				rules[w.rule_index] = '{protocol: w.protocol, src_addr: w.src_addr,
					src_mask: w.src_mask, dst_addr: w.dst_addr, dst_mask: w.dst_mask,
					direction: w.direction, sport: w.sport, dport: w.dport,
					ack_mask: w.ack_bits, verdict: w.rule_verdict};
				rule_writes++;
				return;
			end
			// counts above the table size are clipped
			scan = (rule_count > SLOTS) ? SLOTS : int'(rule_count);
			want = '{matched: 1'b0, match_index: 6'd0, verdict: default_verdict};
			for (int i = 0; i < scan; i++) begin
				if (rule_hits(rules[i], w)) begin
					want = '{matched: 1'b1, match_index: 6'(i), verdict: rules[i].verdict};
					hits++;
					break;
				end
			end
			classified++;
			expected_verdicts.push_back(want);
		endfunction

		function void check_result(prfm_pkg::result_t got);
			prfm_pkg::result_t want;
			if (expected_verdicts.size() == 0) begin
				$error("result word %h arrived with no classify outstanding", got);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			if (got.matched !== want.matched) begin
				$error("matched: expected %0d, got %0d", want.matched, got.matched);
				errors++;
			end
			if (got.match_index !== want.match_index) begin
				$error("match_index: expected %0d, got %0d", want.match_index, got.match_index);
				errors++;
			end
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic              cfg_index = prfm_pkg::REG_RULE_COUNT;
	logic [7:0]        cfg_data = '0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	prfm_pkg::item_t   item = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	prfm_pkg::result_t result;

	// steady: no random idling on either side
	bit steady = 1'b0;
	// set by the stimulus, picked up and counted down by the receiver
	bit hold_request = 1'b0;
	int hold_left = 0;

	verdict_board board = new();

	packet_rule_first_match i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// fully random word, protocol leaning towards the common ones
	function automatic prfm_pkg::item_t noise_word();
		prfm_pkg::item_t w;
		logic [191:0]    raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(prfm_pkg::item_t)-1:0];
		w.action = prfm_pkg::ACT_CLASSIFY;
		case ($urandom_range(0, 4))
			0: w.protocol = prfm_pkg::PROTO_TCP;
			1: w.protocol = PROTO_UDP;
			2: w.protocol = PROTO_ICMP;
			default: w.protocol = 8'($urandom);
		endcase
		return w;
	endfunction

	function automatic logic [31:0] rule_mask();
		int len;
		len = $urandom_range(0, 32);
		if ($urandom_range(0, 4) == 0) return $urandom;
		if (len == 0) return 32'h0;
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 4))
			0: return prfm_pkg::PORT_ANY;
			1: return prfm_pkg::PORT_HIGH;
			2: return 16'($urandom_range(0, 2047));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic prfm_pkg::item_t random_rule(int slot);
		prfm_pkg::item_t w;
		w = noise_word();
		w.action = prfm_pkg::ACT_WRITE;
		w.rule_index = 6'(slot);
		w.src_mask = rule_mask();
		w.dst_mask = rule_mask();
		if ($urandom_range(0, 2) == 0) w.protocol = prfm_pkg::PROTO_ANY;
		// a zero direction mask is a dead rule, keep it rare
		w.direction = ($urandom_range(0, 9) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
		w.sport = pick_port();
		w.dport = pick_port();
		if ($urandom_range(0, 1) == 1) w.ack_bits = prfm_pkg::ACK_ANY;
		return w;
	endfunction

	function automatic logic [15:0] port_for(logic [15:0] rp, logic [15:0] pp);
		if (rp == prfm_pkg::PORT_ANY) return pp;
		if (rp == prfm_pkg::PORT_HIGH && $urandom_range(0, 1) == 1)
			return 16'($urandom_range(prfm_pkg::PORT_HIGH, 16'hFFFF));
		return rp;
	endfunction

	// packet built to hit rule r, sometimes knocked off by one bit
	function automatic prfm_pkg::item_t packet_for(prfm_pkg::rule_t r);
		prfm_pkg::item_t p;
		p = noise_word();
		if (r.protocol != prfm_pkg::PROTO_ANY) begin
			p.protocol = r.protocol;
		end else if (r.ack_mask != prfm_pkg::ACK_ANY) begin
			p.protocol = prfm_pkg::PROTO_TCP;
		end
		p.src_addr = (r.src_addr & r.src_mask) | (p.src_addr & ~r.src_mask);
		p.dst_addr = (r.dst_addr & r.dst_mask) | (p.dst_addr & ~r.dst_mask);
		if (r.direction != 2'd0) begin
			while ((p.direction & r.direction) == 2'd0) p.direction = 2'($urandom_range(1, 3));
		end
		p.sport = port_for(r.sport, p.sport);
		p.dport = port_for(r.dport, p.dport);
		p.ack_bits = p.ack_bits & r.ack_mask;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 5))
				0: p.protocol = p.protocol ^ (8'd1 << $urandom_range(0, 7));
				1: p.src_addr = p.src_addr ^ (32'd1 << $urandom_range(0, 31));
				2: p.dst_addr = p.dst_addr ^ (32'd1 << $urandom_range(0, 31));
				3: p.sport = p.sport ^ (16'd1 << $urandom_range(0, 15));
				4: p.dport = p.dport ^ (16'd1 << $urandom_range(0, 15));
				default: p.ack_bits = p.ack_bits ^ (2'd1 << $urandom_range(0, 1));
			endcase
		end
		return p;
	endfunction

	function automatic prfm_pkg::item_t random_word(logic [7:0] count);
		int live;
		live = (count > SLOTS) ? SLOTS : int'(count);
		if ($urandom_range(0, 99) < 12) return random_rule($urandom_range(0, SLOTS - 1));
		if (live > 0 && $urandom_range(0, 99) < 65)
			return packet_for(board.rules[$urandom_range(0, live - 1)]);
		return noise_word();
	endfunction

	function automatic prfm_pkg::item_t rule_word(int slot, logic [7:0] proto,
			logic [31:0] saddr, logic [31:0] smask, logic [31:0] daddr, logic [31:0] dmask,
			logic [1:0] dir, logic [15:0] sport, logic [15:0] dport, logic [1:0] ack,
			logic [7:0] verdict);
		prfm_pkg::item_t w;
		w = '{action: prfm_pkg::ACT_WRITE, rule_index: 6'(slot), protocol: proto,
			src_addr: saddr, src_mask: smask, dst_addr: daddr, dst_mask: dmask,
			direction: dir, sport: sport, dport: dport, ack_bits: ack,
			rule_verdict: verdict};
		return w;
	endfunction

	function automatic prfm_pkg::item_t packet_word(logic [7:0] proto, logic [31:0] saddr,
			logic [31:0] daddr, logic [1:0] dir, logic [15:0] sport, logic [15:0] dport,
			logic [1:0] ack);
		prfm_pkg::item_t w;
		w = noise_word();
		w.protocol = proto;
		w.src_addr = saddr;
		w.dst_addr = daddr;
		w.direction = dir;
		w.sport = sport;
		w.dport = dport;
		w.ack_bits = ack;
		return w;
	endfunction

	// offers one word, returns at the edge that accepts it with valid still high
	task automatic send_word(input prfm_pkg::item_t w);
		while (!steady && $urandom_range(0, 99) < 8) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		board.note_word(w);
	endtask

	// sender stops until every verdict is back, then lets a trailing write settle
	task automatic drain();
		item_valid <= 1'b0;
		while (board.expected_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.set_reg(idx, value);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// result side: checks each word taken, idles at random or holds off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) board.check_result(result);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= steady || $urandom_range(0, 99) >= 8;
			end
		end
	end

	initial begin
		logic [7:0] phase_count [PHASES];
		phase_count = '{8'd64, 8'd127, 8'd1, 8'd100, 8'd32, 8'd0, 8'd64};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty scan: rule_count is still zero from reset, so the default comes back
		write_reg(prfm_pkg::REG_DEFAULT_VERDICT, 8'hFF);
		send_word(packet_word(prfm_pkg::PROTO_TCP, 32'h0A00_0001, 32'h0A00_0002, 2'd1,
			16'd1, 16'd2, 2'd0));

		// small hand-made table: tcp subnet rule, all-ones high-port rule, udp rule,
		// dead rule with no direction, tcp-only ack rule, catch-all
		send_word(rule_word(0, prfm_pkg::PROTO_TCP, 32'h0A00_0000, 32'hFF00_0000,
			32'hC0A8_0100, 32'hFFFF_FF00, 2'd1, prfm_pkg::PORT_ANY, 16'd80, 2'd1, 8'h11));
		send_word(rule_word(1, prfm_pkg::PROTO_ANY, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2, prfm_pkg::PORT_HIGH, prfm_pkg::PORT_HIGH,
			prfm_pkg::ACK_ANY, 8'hFF));
		send_word(rule_word(2, PROTO_UDP, 32'hDEAD_BEEF, 32'h0, 32'h1234_5678, 32'h0,
			2'd3, 16'hFFFF, prfm_pkg::PORT_ANY, prfm_pkg::ACK_ANY, 8'h22));
		send_word(rule_word(3, prfm_pkg::PROTO_ANY, 32'h0, 32'h0, 32'h0, 32'h0, 2'd0,
			prfm_pkg::PORT_ANY, prfm_pkg::PORT_ANY, prfm_pkg::ACK_ANY, 8'h33));
		send_word(rule_word(4, prfm_pkg::PROTO_ANY, 32'h0, 32'h0, 32'h0, 32'h0, 2'd3,
			prfm_pkg::PORT_ANY, prfm_pkg::PORT_ANY, 2'd0, 8'h44));
		send_word(rule_word(5, prfm_pkg::PROTO_ANY, 32'h0, 32'h0, 32'h0, 32'h0, 2'd3,
			prfm_pkg::PORT_ANY, prfm_pkg::PORT_ANY, prfm_pkg::ACK_ANY, 8'h55));
		drain();
		write_reg(prfm_pkg::REG_RULE_COUNT, 8'd6);
		write_reg(prfm_pkg::REG_DEFAULT_VERDICT, 8'h00);

		// hit on the first slot, then the same packet with ack bits outside the mask
		send_word(packet_word(prfm_pkg::PROTO_TCP, 32'h0A01_0203, 32'hC0A8_0107, 2'd1,
			16'd5000, 16'd80, 2'd1));
		send_word(packet_word(prfm_pkg::PROTO_TCP, 32'h0A01_0203, 32'hC0A8_0107, 2'd1,
			16'd5000, 16'd80, 2'd3));
		// high-port rule at its edge: 1023 hits, 1022 falls through
		send_word(packet_word(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2, 16'd1023,
			16'hFFFF, 2'd3));
		send_word(packet_word(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2, 16'd1022,
			16'hFFFF, 2'd3));
		send_word(packet_word(PROTO_UDP, 32'h0, 32'h0, 2'd3, 16'hFFFF, 16'h0, 2'd0));
		send_word(packet_word(prfm_pkg::PROTO_TCP, 32'h1234_5678, 32'h9ABC_DEF0, 2'd2,
			16'd443, 16'd8080, 2'd0));
		// ack-restricted rule needs tcp, so icmp ends on the catch-all
		send_word(packet_word(PROTO_ICMP, 32'h0102_0304, 32'h0506_0708, 2'd1, 16'd0,
			16'd0, 2'd0));
		drain();

		// without the catch-all the same packet misses
		write_reg(prfm_pkg::REG_RULE_COUNT, 8'd5);
		send_word(packet_word(PROTO_ICMP, 32'h0102_0304, 32'h0506_0708, 2'd1, 16'd0,
			16'd0, 2'd0));

		// fill every slot so any rule_count scans written rules only
		for (int s = 0; s < SLOTS; s++) send_word(random_rule(s));

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_reg(prfm_pkg::REG_RULE_COUNT, phase_count[ph]);
			write_reg(prfm_pkg::REG_DEFAULT_VERDICT,
				(ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom));
			// one phase with no idling at all
			steady = (ph == 4);
			// long result stall while the sender keeps offering words
			if (ph == 1) hold_request = 1'b1;
			for (int k = 0; k < WORDS_PER_PHASE; k++) send_word(random_word(phase_count[ph]));
		end
		drain();

		$display("%0d packets classified (%0d rule hits, %0d defaults), %0d rule writes",
			board.classified, board.hits, board.classified - board.hits, board.rule_writes);
		$display("rule counts from 0 past the table size, one long result stall");
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog, several times the slowest expected run
	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/prfm_pkg.sv
hw/rtl/prfm_rule_match.sv
hw/rtl/packet_rule_first_match.sv
sim/packet_rule_first_match_test.sv
